// ----- hw/rtl/lcwc_pkg.sv -----
package lcwc_pkg;

  localparam int WEIGHT_FRAC_BITS = 6;
  localparam int COS_FRAC_BITS = 15;
  localparam int PROD_FRAC_BITS = 2 * COS_FRAC_BITS;

  localparam logic [31:0] ONE_W = 32'(1 << WEIGHT_FRAC_BITS);
  localparam logic [31:0] HALF_W = 32'((1 << WEIGHT_FRAC_BITS) >> 1);
  localparam logic [32:0] IDLE_LIMIT = 33'(250 << WEIGHT_FRAC_BITS);
  localparam logic [32:0] SPIKE_JUMP = 33'(600 << WEIGHT_FRAC_BITS);
  localparam logic signed [31:0] MIN_VALID = 32'(-(9000 << WEIGHT_FRAC_BITS));
  localparam logic [31:0] HIT_SPACING_MS = 32'd1000;
  localparam logic [7:0] ZERO_HITS_FOR_TARE = 8'd5;
  localparam logic [31:0] COS_PROD_MIN = 32'((64'd5 << PROD_FRAC_BITS) / 64'd100);
  localparam longint PI_OVER_180_Q30 = 64'sd18740330;

  // floor(y / 5) = (y * DIV5_MAGIC) >> DIV5_SHIFT, exact for any 32-bit y
  localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV5_SHIFT = 34;

  typedef enum logic [1:0] {
    CFG_SPIKE_EN  = 2'd0,
    CFG_NEGATE    = 2'd1,
    CFG_TILT_THR  = 2'd2,
    CFG_MAX_W     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic load_in;
    logic filt;
    logic fdiv_start;
    logic fdiv_done;
    logic post;
    logic mul;
    logic tdiv_start;
    logic tdiv_done;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_fdiv;
    logic tilt_apply;
    logic div_done;
  } dp_status_t;

  // long division of non-negative values, elaboration use only
  function automatic longint udiv_pos(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((n >>> i) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // cos(k deg), k in 0..90, Taylor series in Q30, evaluated at elaboration
  function automatic logic signed [15:0] cos_q(input int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    longint den;
    x = longint'(k) * PI_OVER_180_Q30;
    x2 = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum = term;
    for (int n = 0; n < 7; n++) begin
      den = longint'((2 * n + 1) * (2 * n + 2));
      term = udiv_pos((term * x2) >>> 30, den);
      if ((n & 1) == 1) sum = sum + term;
      else sum = sum - term;
    end
    if (sum < 0) sum = 0;
    r = (sum + (64'sd1 <<< (29 - COS_FRAC_BITS))) >>> (30 - COS_FRAC_BITS);
    if (r > (64'sd1 <<< COS_FRAC_BITS) - 1) r = (64'sd1 <<< COS_FRAC_BITS) - 1;
    return 16'(r);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ----- hw/rtl/lcwc_if.sv -----
interface lcwc_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] raw_weight;
  logic [31:0] now_ms;
  logic signed [12:0] roll_angle;
  logic signed [12:0] pitch_angle;
  modport source (output valid, raw_weight, now_ms, roll_angle, pitch_angle, input ready);
  modport sink (input valid, raw_weight, now_ms, roll_angle, pitch_angle, output ready);
endinterface

interface lcwc_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] weight_out;
  logic weight_error;
  logic tare_request;
  modport source (output valid, weight_out, weight_error, tare_request, input ready);
  modport sink (input valid, weight_out, weight_error, tare_request, output ready);
endinterface

interface lcwc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/lcwc_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module lcwc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quotient[63]};
  assign diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        rem <= '0;
        dvs <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/lcwc_ctrl.sv -----
module lcwc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lcwc_pkg::dp_status_t  status,
  output lcwc_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    IDLE, FILT, FDIV, POST, MUL, TILT, TDIV, DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.load_in    = (state == IDLE) && in_valid;
    cmd.filt       = (state == FILT);
    cmd.fdiv_start = (state == FILT) && status.need_fdiv;
    cmd.fdiv_done  = (state == FDIV);
    cmd.post       = (state == POST);
    cmd.mul        = (state == MUL);
    cmd.tdiv_start = (state == TILT) && status.tilt_apply;
    cmd.tdiv_done  = (state == TDIV) && status.div_done;
    cmd.load_out   = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == DONE) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (in_valid) state <= FILT;
        FILT: state <= status.need_fdiv ? FDIV : POST;
        FDIV: state <= POST;
        POST: state <= MUL;
        MUL:  state <= TILT;
        TILT: state <= status.tilt_apply ? TDIV : DONE;
        TDIV: if (status.div_done) state <= DONE;
        DONE: if (out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lcwc_dp.sv -----
module lcwc_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lcwc_pkg::dp_cmd_t     cmd,
  output lcwc_pkg::dp_status_t  status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    raw_weight,
  input  logic [31:0]           now_ms,
  input  logic signed [12:0]    roll_angle,
  input  logic signed [12:0]    pitch_angle,
  output logic signed [31:0]    weight_out,
  output logic                  weight_error,
  output logic                  tare_request
);

  // configuration
  logic        spike_en;
  logic        negate;
  logic [10:0] tilt_thr;
  logic [30:0] max_w;

  // sample
  logic signed [31:0] w_in;
  logic [31:0]        now;
  logic signed [12:0] roll;
  logic signed [12:0] pitch;

  // state
  logic signed [31:0] filt_w;
  logic               primed;
  logic [7:0]         spike_streak;
  logic [7:0]         zero_streak;
  logic [31:0]        last_time;

  // work registers
  logic signed [31:0] w;
  logic               tare;
  logic signed [15:0] cos_r;
  logic signed [15:0] cos_p;
  logic               tilt_on;
  logic signed [31:0] prod;
  logic               blend_neg;
  logic [31:0]        blend_half;

  logic signed [15:0] cos_rom [0:90];
  for (genvar k = 0; k <= 90; k++) begin : g_cos
    assign cos_rom[k] = lcwc_pkg::cos_q(k);
  end

  function automatic logic signed [15:0] cos_lookup(input logic signed [12:0] a);
    logic [12:0] mag;
    logic [8:0]  d;
    logic [8:0]  f;
    logic signed [15:0] c;
    mag = a[12] ? 13'(-a) : 13'(a);
    d = 9'((mag + 13'd8) >> 4);
    f = (d > 9'd180) ? 9'd360 - d : d;
    if (f <= 9'd90) c = cos_rom[f[6:0]];
    else c = -cos_rom[7'(9'd180 - f)];
    return c;
  endfunction

  // divider
  logic        div_start;
  logic [63:0] div_n;
  logic [31:0] div_d;
  logic [63:0] div_q;
  logic        div_done;

  lcwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // smoothing
  logic signed [32:0] diff;
  logic               near_idle;
  logic               spike;
  logic [7:0]         streak_inc;
  logic signed [35:0] blend;
  logic [35:0]        blend_mag;
  logic signed [34:0] ema;
  logic [63:0]        blend_prod;
  logic [31:0]        blend_q;

  assign diff = 33'(filt_w) - 33'(w_in);
  assign near_idle = {1'b0, lcwc_pkg::abs32(filt_w)} < lcwc_pkg::IDLE_LIMIT;
  assign spike = near_idle && ((diff[32] ? 33'(-diff) : diff) > lcwc_pkg::SPIKE_JUMP);
  assign streak_inc = (spike_streak == 8'hFF) ? spike_streak : spike_streak + 8'd1;
  assign blend = 36'sd7 * 36'(filt_w) + 36'sd3 * 36'(w_in);
  assign blend_mag = blend[35] ? 36'(-blend) : 36'(blend);
  assign ema = (35'sd3 * 35'(filt_w) + 35'(w_in)) >>> 2;

  // floor(x / 10) = floor(floor(x / 2) / 5); a negative blend rounds its
  // magnitude up by adding 9 first
  assign blend_prod = blend_half * lcwc_pkg::DIV5_MAGIC;
  assign blend_q = 32'(blend_prod >> lcwc_pkg::DIV5_SHIFT);

  assign status.need_fdiv = spike_en && primed && spike && (streak_inc > 8'd2);

  // deadband and near-zero streak
  logic signed [31:0] w0;
  logic [31:0]        mag0;
  logic               hit;
  logic               countable;
  logic [7:0]         zs_hit;
  logic [31:0]        elapsed;

  assign w0 = spike_en ? filt_w : w_in;
  assign mag0 = lcwc_pkg::abs32(w0);
  assign hit = (mag0 > lcwc_pkg::HALF_W) && (mag0 <= lcwc_pkg::ONE_W);
  assign elapsed = now - last_time;
  assign countable = (last_time == 32'd0) || (elapsed >= lcwc_pkg::HIT_SPACING_MS);
  assign zs_hit = (countable && zero_streak != 8'hFF) ? zero_streak + 8'd1 : zero_streak;

  // tilt
  logic [31:0] abs_w;
  logic [12:0] roll_mag;
  logic [12:0] pitch_mag;

  assign abs_w = lcwc_pkg::abs32(w);
  assign roll_mag = roll[12] ? 13'(-roll) : 13'(roll);
  assign pitch_mag = pitch[12] ? 13'(-pitch) : 13'(pitch);
  assign status.tilt_apply = tilt_on && !prod[31] && (prod != 32'sd0) &&
                             (32'(prod) >= lcwc_pkg::COS_PROD_MIN);
  assign status.div_done = div_done;

  assign div_start = cmd.tdiv_start;
  assign div_n = {2'b0, abs_w, 30'b0} + 64'(32'(prod) >> 1);
  assign div_d = 32'(prod);

  logic signed [31:0] tilt_res;
  always_comb begin
    if (w[31]) begin
      tilt_res = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q);
    end else begin
      tilt_res = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_en <= 1'b0;
      negate <= 1'b0;
      tilt_thr <= 11'd320;
      max_w <= 31'd3200000;
      filt_w <= '0;
      primed <= 1'b0;
      spike_streak <= '0;
      zero_streak <= '0;
      last_time <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcwc_pkg::CFG_SPIKE_EN: spike_en <= cfg_data[0];
          lcwc_pkg::CFG_NEGATE:   negate <= cfg_data[0];
          lcwc_pkg::CFG_TILT_THR: tilt_thr <= cfg_data[10:0];
          lcwc_pkg::CFG_MAX_W:    max_w <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (cmd.filt && spike_en) begin
        if (!primed) begin
          filt_w <= w_in;
          primed <= 1'b1;
        end else if (spike) begin
          spike_streak <= streak_inc;
        end else begin
          spike_streak <= '0;
          filt_w <= ema[31:0];
        end
      end
      if (cmd.fdiv_done) begin
        filt_w <= blend_neg ? 32'(-blend_q) : blend_q;
      end

      if (cmd.post) begin
        if (hit) begin
          if (zs_hit >= lcwc_pkg::ZERO_HITS_FOR_TARE) begin
            zero_streak <= '0;
            last_time <= '0;
          end else begin
            zero_streak <= zs_hit;
            if (countable) last_time <= now;
          end
        end else begin
          zero_streak <= '0;
          last_time <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w_in <= raw_weight;
      now <= now_ms;
      roll <= roll_angle;
      pitch <= pitch_angle;
    end
    if (cmd.fdiv_start) begin
      blend_neg <= blend[35];
      blend_half <= 32'((blend_mag + (blend[35] ? 36'd9 : 36'd0)) >> 1);
    end
    if (cmd.post) begin
      logic signed [31:0] wp;
      logic               tp;
      wp = (mag0 <= lcwc_pkg::HALF_W) ? 32'sd0 : w0;
      tp = hit && (zs_hit >= lcwc_pkg::ZERO_HITS_FOR_TARE);
      if (tp) wp = 32'sd0;
      if (negate) wp = (wp == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -wp;
      w <= wp;
      tare <= tp;
      cos_r <= cos_lookup(roll);
      cos_p <= cos_lookup(pitch);
      tilt_on <= ({1'b0, roll_mag} > 14'(tilt_thr)) || ({1'b0, pitch_mag} > 14'(tilt_thr));
    end
    if (cmd.mul) prod <= cos_r * cos_p;
    if (cmd.tdiv_done) w <= tilt_res;
    if (cmd.load_out) begin
      weight_out <= w;
      weight_error <= !((w > lcwc_pkg::MIN_VALID) && (abs_w <= {1'b0, max_w}));
      tare_request <= tare;
    end
  end

endmodule

// ----- hw/rtl/load_cell_weight_conditioner_core.sv -----
// Load cell weight conditioner.
// Channels: sample (sink) carries one calibrated reading with its ms timestamp and
// roll/pitch in 1/16 degree; result (source) returns the conditioned weight in
// 1/64 g, a plausibility error flag and a tare request, one result per sample.
// cfg (sink) writes the four control registers; it is always ready and may only
// be written while no transaction is in flight.
// Steps: the sample is smoothed, a long spike is blended when needed (divide by
// ten as a reciprocal multiply), deadband, tare and negation are applied and the
// cosines looked up and multiplied, then tilt correction, when it applies, runs
// the 64-step radix-2 tilt divider. One sample is processed at a time; the next
// one can be taken in the same cycle as the result goes valid.
// A finished result sits in the output register while the next sample is taken,
// so a stalled receiver costs nothing until a second result is ready; the block
// then holds in its final step until the output register frees up.
// Reset (rst, synchronous): filter, spike and near-zero streaks cleared, registers
// to defaults (filter off, no negation, tilt threshold 320, max weight 3200000).
module load_cell_weight_conditioner_core (
  input  logic clk,
  input  logic rst,
  lcwc_in_if.sink    sample,
  lcwc_out_if.source result,
  lcwc_cfg_if.sink   cfg
);

  lcwc_pkg::dp_cmd_t    cmd;
  lcwc_pkg::dp_status_t status;

  // config writes never stall
  assign cfg.ready = 1'b1;

  lcwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcwc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .raw_weight   (sample.raw_weight),
    .now_ms       (sample.now_ms),
    .roll_angle   (sample.roll_angle),
    .pitch_angle  (sample.pitch_angle),
    .weight_out   (result.weight_out),
    .weight_error (result.weight_error),
    .tare_request (result.tare_request)
  );

endmodule
